@@ src/scancode_to_ascii_decoder_top_macros.svh @@
// Assertion macros for the scan-code decoder.
// Used by scd_in_stage and scd_decode; expects clk and rst in the scope of each use.
`ifndef SCANCODE_TO_ASCII_DECODER_TOP_MACROS_SVH
`define SCANCODE_TO_ASCII_DECODER_TOP_MACROS_SVH
`ifndef SYNTH
`define SCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCD_ASSERT_IMP(lbl, ante, cons, msg)
`define SCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/scd_pkg.sv @@
// Package of the scan-code decoder: key codes, lock bit positions, result type
// and the two character tables. No dependencies.
package scd_pkg;

  localparam int CODE_W = 8;
  localparam int KEY_W  = 7;
  localparam int CHAR_W = 8;
  localparam int LOCK_W = 3;

  localparam int BREAK_BIT   = 7;
  localparam int LOCK_CAPS   = 2;
  localparam int LOCK_NUM    = 1;
  localparam int LOCK_SCROLL = 0;

  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2a;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3a;
  localparam logic [KEY_W-1:0] KEY_NUM    = 7'h45;
  localparam logic [KEY_W-1:0] KEY_SCROLL = 7'h46;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic              is_make;
    logic [CHAR_W-1:0] char_code;
    logic              is_letter;
    logic [KEY_W-1:0]  key_code;
    logic              led_update;
    logic [LOCK_W-1:0] led_bits;
  } scd_result_t;

  // Entries that both tables share: letters, space, and the keypad.
  function automatic logic [CHAR_W-1:0] scd_common(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    case (key)
      7'h10: ch = 8'h51;
      7'h11: ch = 8'h57;
      7'h12: ch = 8'h45;
      7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;
      7'h15: ch = 8'h59;
      7'h16: ch = 8'h55;
      7'h17: ch = 8'h49;
      7'h18: ch = 8'h4f;
      7'h19: ch = 8'h50;
      7'h1e: ch = 8'h41;
      7'h1f: ch = 8'h53;
      7'h20: ch = 8'h44;
      7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;
      7'h23: ch = 8'h48;
      7'h24: ch = 8'h4a;
      7'h25: ch = 8'h4b;
      7'h26: ch = 8'h4c;
      7'h2c: ch = 8'h5a;
      7'h2d: ch = 8'h58;
      7'h2e: ch = 8'h43;
      7'h2f: ch = 8'h56;
      7'h30: ch = 8'h42;
      7'h31: ch = 8'h4e;
      7'h32: ch = 8'h4d;
      7'h37: ch = 8'h2a;
      7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;
      7'h48: ch = 8'h38;
      7'h49: ch = 8'h39;
      7'h4a: ch = 8'h2d;
      7'h4b: ch = 8'h34;
      7'h4c: ch = 8'h35;
      7'h4d: ch = 8'h36;
      7'h4e: ch = 8'h2b;
      7'h4f: ch = 8'h31;
      7'h50: ch = 8'h32;
      7'h51: ch = 8'h33;
      7'h52: ch = 8'h30;
      7'h53: ch = 8'h2e;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  function automatic logic [CHAR_W-1:0] scd_plain(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    case (key)
      7'h02: ch = 8'h31;
      7'h03: ch = 8'h32;
      7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;
      7'h06: ch = 8'h35;
      7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;
      7'h09: ch = 8'h38;
      7'h0a: ch = 8'h39;
      7'h0b: ch = 8'h30;
      7'h0c: ch = 8'h2d;
      7'h0d: ch = 8'h5e;
      7'h1a: ch = 8'h40;
      7'h1b: ch = 8'h5b;
      7'h27: ch = 8'h3b;
      7'h28: ch = 8'h3a;
      7'h2b: ch = 8'h5d;
      7'h33: ch = 8'h2c;
      7'h34: ch = 8'h2e;
      7'h35: ch = 8'h2f;
      default: ch = scd_common(key);
    endcase
    return ch;
  endfunction

  function automatic logic [CHAR_W-1:0] scd_shifted(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    case (key)
      7'h02: ch = 8'h21;
      7'h03: ch = 8'h22;
      7'h04: ch = 8'h23;
      7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;
      7'h07: ch = 8'h26;
      7'h08: ch = 8'h27;
      7'h09: ch = 8'h28;
      7'h0a: ch = 8'h29;
      7'h0b: ch = 8'h7e;
      7'h0c: ch = 8'h3d;
      7'h0d: ch = 8'h7e;
      7'h1a: ch = 8'h60;
      7'h1b: ch = 8'h7b;
      7'h27: ch = 8'h2b;
      7'h28: ch = 8'h2a;
      7'h2b: ch = 8'h7d;
      7'h33: ch = 8'h3c;
      7'h34: ch = 8'h3e;
      7'h35: ch = 8'h3f;
      7'h73: ch = 8'h5f;
      7'h7d: ch = 8'h7c;
      default: ch = scd_common(key);
    endcase
    return ch;
  endfunction

endpackage

@@ src/scd_channels.sv @@
// Valid/ready channel interfaces of the scan-code decoder.
// Depends on scd_pkg for the field widths.
interface scd_code_if;
  import scd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] scan_code;
  modport source (output valid, output scan_code, input ready);
  modport sink (input valid, input scan_code, output ready);
endinterface

interface scd_char_if;
  import scd_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_make;
  logic [CHAR_W-1:0] char_code;
  logic              is_letter;
  logic [KEY_W-1:0]  key_code;
  logic              led_update;
  logic [LOCK_W-1:0] led_bits;
  modport source (output valid, output is_make, output char_code, output is_letter,
                  output key_code, output led_update, output led_bits, input ready);
  modport sink (input valid, input is_make, input char_code, input is_letter,
                input key_code, input led_update, input led_bits, output ready);
endinterface

@@ src/scd_in_stage.sv @@
// Input register of the scan-code decoder: holds one accepted code beat.
// Depends on scd_pkg, scd_channels and the assertion macro header.
`include "scancode_to_ascii_decoder_top_macros.svh"

module scd_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  scd_code_if.sink                  codes,
  input  logic                      advance,
  output logic                      held,
  output logic [scd_pkg::CODE_W-1:0] code
);
  import scd_pkg::*;

  logic take;

  // A new beat enters when the register is empty or when the held one moves on in the same cycle.
  assign codes.ready = !held || advance;
  assign take        = codes.valid && codes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code <= codes.scan_code;
    end
  end

  `SCD_ASSERT_NXT(a_take_holds, take, held, "accepted code beat was not held")
  `SCD_ASSERT_NXT(a_stall_keeps, held && !advance, held && $stable(code),
                  "stalled code was lost or changed")
endmodule

@@ src/scd_decode.sv @@
// Decode stage: shift and lock state plus the table lookup for one code.
// Depends on scd_pkg and the assertion macro header.
`include "scancode_to_ascii_decoder_top_macros.svh"

module scd_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [scd_pkg::CODE_W-1:0] code,
  input  logic                       cfg_we,
  input  logic [scd_pkg::LOCK_W-1:0] cfg_wdata,
  output scd_pkg::scd_result_t       result
);
  import scd_pkg::*;

  logic [1:0]        shift_held, shift_held_next;
  logic [LOCK_W-1:0] lock_bits, lock_bits_next;
  logic              make;
  logic [KEY_W-1:0]  key;
  logic              led_upd;
  logic [CHAR_W-1:0] ch_raw;
  logic              letter;
  logic              to_lower;

  assign make = !code[BREAK_BIT];
  assign key  = code[KEY_W-1:0];

  always_comb begin
    shift_held_next = shift_held;
    lock_bits_next  = lock_bits;
    led_upd         = 1'b0;
    if (make) begin
      case (key)
        KEY_LSHIFT: shift_held_next[0] = 1'b1;
        KEY_RSHIFT: shift_held_next[1] = 1'b1;
        KEY_CAPS: begin
          lock_bits_next[LOCK_CAPS] = !lock_bits[LOCK_CAPS];
          led_upd = 1'b1;
        end
        KEY_NUM: begin
          lock_bits_next[LOCK_NUM] = !lock_bits[LOCK_NUM];
          led_upd = 1'b1;
        end
        KEY_SCROLL: begin
          lock_bits_next[LOCK_SCROLL] = !lock_bits[LOCK_SCROLL];
          led_upd = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (key)
        KEY_LSHIFT: shift_held_next[0] = 1'b0;
        KEY_RSHIFT: shift_held_next[1] = 1'b0;
        default: ;
      endcase
    end
  end

  // The lookup uses the shift state after this code has been applied.
  assign ch_raw   = (shift_held_next == 2'b00) ? scd_plain(key) : scd_shifted(key);
  assign letter   = ch_raw inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
  assign to_lower = lock_bits_next[LOCK_CAPS] == (shift_held_next != 2'b00);

  always_comb begin
    result.is_make    = make;
    result.char_code  = (letter && to_lower) ? ch_raw + CASE_OFFSET : ch_raw;
    result.is_letter  = letter;
    result.key_code   = key;
    result.led_update = led_upd;
    result.led_bits   = lock_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= '0;
      lock_bits  <= '0;
    end else begin
      if (step) begin
        shift_held <= shift_held_next;
      end
      if (cfg_we) begin
        lock_bits <= cfg_wdata;
      end else if (step) begin
        lock_bits <= lock_bits_next;
      end
    end
  end

  `SCD_ASSERT_IMP(a_led_only_locks, step && result.led_update,
                  make && (key == KEY_CAPS || key == KEY_NUM || key == KEY_SCROLL),
                  "LED update on a code that is not a lock make")
  `SCD_ASSERT_NXT(a_locks_steady, step && !result.led_update && !cfg_we,
                  $stable(lock_bits), "lock bits moved without a lock key")
  `SCD_ASSERT_NXT(a_shift_only_shift_keys, step && key != KEY_LSHIFT && key != KEY_RSHIFT,
                  $stable(shift_held), "shift state moved on another key")
endmodule

@@ src/scd_out_stage.sv @@
// Result register of the scan-code decoder, drives the character channel.
// Depends on scd_pkg and scd_channels.
module scd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  scd_pkg::scd_result_t result,
  output logic                 free,
  scd_char_if.source           chars
);
  import scd_pkg::*;

  logic        valid;
  scd_result_t data;

  // The register can take a new result when empty or when its beat leaves now.
  assign free = !valid || chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (chars.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign chars.valid      = valid;
  assign chars.is_make    = data.is_make;
  assign chars.char_code  = data.char_code;
  assign chars.is_letter  = data.is_letter;
  assign chars.key_code   = data.key_code;
  assign chars.led_update = data.led_update;
  assign chars.led_bits   = data.led_bits;
endmodule

@@ src/scancode_to_ascii_decoder_top.sv @@
// Top level of the set 1 scan-code to character decoder.
// Depends on scd_pkg, scd_channels, scd_in_stage, scd_decode and scd_out_stage.
//
//   Port     Kind            Direction  Payload
//   codes    valid/ready     in         scan_code
//   chars    valid/ready     out        is_make char_code is_letter key_code
//                                       led_update led_bits
//   cfg_we   write strobe    in         cfg_wdata (boot lock bits)
//
// One beat per cycle sustained while chars.ready stays high; the result beat of a code
// passes through the input register and then the result register around the lookup
// before it can be taken on chars.
// Synchronous reset clears both stages, shift state and lock bits.
// A stall on chars holds the result and then the input register; codes.ready
// drops only when both are full and chars.ready is low.
module scancode_to_ascii_decoder_top (
  input  logic                       clk,
  input  logic                       rst,
  scd_code_if.sink                   codes,
  scd_char_if.source                 chars,
  input  logic                       cfg_we,
  input  logic [scd_pkg::LOCK_W-1:0] cfg_wdata
);
  import scd_pkg::*;

  logic              held;
  logic [CODE_W-1:0] code;
  logic              free;
  logic              step;
  scd_result_t       result;

  assign step = held && free;

  scd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .codes   (codes),
    .advance (free),
    .held    (held),
    .code    (code)
  );

  scd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .code      (code),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  scd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .result (result),
    .free   (free),
    .chars  (chars)
  );
endmodule

@@ tb/scd_checker.sv @@
// Scoreboard for the scan-code decoder: predicts each result from the accepted codes
// and compares the result beats field by field. Depends on scd_pkg and scd_channels.
module scd_checker (
  input  logic                       clk,
  input  logic                       rst,
  scd_code_if                        codes,
  scd_char_if                        chars,
  input  logic                       cfg_we,
  input  logic [scd_pkg::LOCK_W-1:0] cfg_wdata,
  output int                         errors,
  output int                         pending,
  output int                         checked
);
  import scd_pkg::*;

  logic [1:0]        shift_state;
  logic [LOCK_W-1:0] lock_state;
  scd_result_t       expected_chars[$];
  scd_result_t       want;

  // Character tables of the Japanese set 1 layout; shifted selects the upper row.
  function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key,
                                                 input logic shifted);
    logic [CHAR_W-1:0] ch;
    ch = 8'h00;
    case (key)
      7'h02: ch = shifted ? 8'h21 : 8'h31;
      7'h03: ch = shifted ? 8'h22 : 8'h32;
      7'h04: ch = shifted ? 8'h23 : 8'h33;
      7'h05: ch = shifted ? 8'h24 : 8'h34;
      7'h06: ch = shifted ? 8'h25 : 8'h35;
      7'h07: ch = shifted ? 8'h26 : 8'h36;
      7'h08: ch = shifted ? 8'h27 : 8'h37;
      7'h09: ch = shifted ? 8'h28 : 8'h38;
      7'h0a: ch = shifted ? 8'h29 : 8'h39;
      7'h0b: ch = shifted ? 8'h7e : 8'h30;
      7'h0c: ch = shifted ? 8'h3d : 8'h2d;
      7'h0d: ch = shifted ? 8'h7e : 8'h5e;
      7'h10: ch = 8'h51;
      7'h11: ch = 8'h57;
      7'h12: ch = 8'h45;
      7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;
      7'h15: ch = 8'h59;
      7'h16: ch = 8'h55;
      7'h17: ch = 8'h49;
      7'h18: ch = 8'h4f;
      7'h19: ch = 8'h50;
      7'h1a: ch = shifted ? 8'h60 : 8'h40;
      7'h1b: ch = shifted ? 8'h7b : 8'h5b;
      7'h1e: ch = 8'h41;
      7'h1f: ch = 8'h53;
      7'h20: ch = 8'h44;
      7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;
      7'h23: ch = 8'h48;
      7'h24: ch = 8'h4a;
      7'h25: ch = 8'h4b;
      7'h26: ch = 8'h4c;
      7'h27: ch = shifted ? 8'h2b : 8'h3b;
      7'h28: ch = shifted ? 8'h2a : 8'h3a;
      7'h2b: ch = shifted ? 8'h7d : 8'h5d;
      7'h2c: ch = 8'h5a;
      7'h2d: ch = 8'h58;
      7'h2e: ch = 8'h43;
      7'h2f: ch = 8'h56;
      7'h30: ch = 8'h42;
      7'h31: ch = 8'h4e;
      7'h32: ch = 8'h4d;
      7'h33: ch = shifted ? 8'h3c : 8'h2c;
      7'h34: ch = shifted ? 8'h3e : 8'h2e;
      7'h35: ch = shifted ? 8'h3f : 8'h2f;
      7'h37: ch = 8'h2a;
      7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;
      7'h48: ch = 8'h38;
      7'h49: ch = 8'h39;
      7'h4a: ch = 8'h2d;
      7'h4b: ch = 8'h34;
      7'h4c: ch = 8'h35;
      7'h4d: ch = 8'h36;
      7'h4e: ch = 8'h2b;
      7'h4f: ch = 8'h31;
      7'h50: ch = 8'h32;
      7'h51: ch = 8'h33;
      7'h52: ch = 8'h30;
      7'h53: ch = 8'h2e;
      7'h73: ch = shifted ? 8'h5f : 8'h00;
      7'h7d: ch = shifted ? 8'h7c : 8'h00;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Updates the shift and lock state for one code and returns the expected beat.
  function automatic scd_result_t decode_code(input logic [CODE_W-1:0] code);
    scd_result_t r;
    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] ch;
    key = code[KEY_W-1:0];
    r = '0;
    r.is_make  = !code[BREAK_BIT];
    r.key_code = key;
    if (r.is_make) begin
      case (key)
        KEY_LSHIFT: shift_state[0] = 1'b1;
        KEY_RSHIFT: shift_state[1] = 1'b1;
        KEY_CAPS: begin
          lock_state[LOCK_CAPS] = !lock_state[LOCK_CAPS];
          r.led_update = 1'b1;
        end
        KEY_NUM: begin
          lock_state[LOCK_NUM] = !lock_state[LOCK_NUM];
          r.led_update = 1'b1;
        end
        KEY_SCROLL: begin
          lock_state[LOCK_SCROLL] = !lock_state[LOCK_SCROLL];
          r.led_update = 1'b1;
        end
        default: ;
      endcase
    end else begin
      // Lock keys do nothing on release; only the shift bits are cleared.
      if (key == KEY_LSHIFT) shift_state[0] = 1'b0;
      else if (key == KEY_RSHIFT) shift_state[1] = 1'b0;
    end
    ch = key_char(key, shift_state != 2'b00);
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      // Uppercase stays only when exactly one of caps lock and shift is active.
      if (lock_state[LOCK_CAPS] == (shift_state != 2'b00)) ch = ch + CASE_OFFSET;
      r.is_letter = 1'b1;
    end
    r.char_code = ch;
    r.led_bits  = lock_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
             checked, what, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shift_state = 2'b00;
      lock_state  = '0;
      expected_chars.delete();
      pending <= 0;
    end else begin
      if (cfg_we) lock_state = cfg_wdata;
      if (codes.valid && codes.ready) expected_chars.push_back(decode_code(codes.scan_code));
      if (chars.valid && chars.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("beat with nothing expected, key_code", chars.key_code, 0);
        end else begin
          want = expected_chars.pop_front();
          if (chars.is_make !== want.is_make)
            report_mismatch("is_make", chars.is_make, want.is_make);
          if (chars.char_code !== want.char_code)
            report_mismatch("char_code", chars.char_code, want.char_code);
          if (chars.is_letter !== want.is_letter)
            report_mismatch("is_letter", chars.is_letter, want.is_letter);
          if (chars.key_code !== want.key_code)
            report_mismatch("key_code", chars.key_code, want.key_code);
          if (chars.led_update !== want.led_update)
            report_mismatch("led_update", chars.led_update, want.led_update);
          if (chars.led_bits !== want.led_bits)
            report_mismatch("led_bits", chars.led_bits, want.led_bits);
        end
        checked++;
      end
      pending <= expected_chars.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top of the scan-code decoder: clock, reset, code stimulus, random stalls
// and the verdict. Depends on scd_pkg, scd_channels, scd_checker and the decoder top.
module tb;
  import scd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 114;
  localparam int DIRECTED_LEN = 26;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [LOCK_W-1:0] cfg_wdata;
  int                idle_pct;
  int                stall_pct;
  int                cycles;
  int                sent;
  int                errors;
  int                pending;
  int                checked;
  logic [CODE_W-1:0] directed_codes [0:DIRECTED_LEN-1];

  scd_code_if codes_ch ();
  scd_char_if chars_ch ();

  scancode_to_ascii_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes_ch),
    .chars     (chars_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  scd_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes_ch),
    .chars     (chars_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    chars_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one code and returns at the edge where its beat is taken.
  task automatic send_code(input logic [CODE_W-1:0] code);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      codes_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    codes_ch.valid     <= 1'b1;
    codes_ch.scan_code <= code;
    @(posedge clk);
    while (!codes_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic press_release(input logic [KEY_W-1:0] key);
    send_code({1'b0, key});
    send_code({1'b1, key});
  endtask

  // Holds the sender off until every predicted beat has come back.
  task automatic drain_results();
    codes_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_boot_locks(input logic [LOCK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One chunk of keyboard traffic: mostly ordinary typing, some raw noise.
  task automatic random_traffic();
    int pick;
    int n;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 50) begin
      key = ($urandom_range(1) == 0) ? KEY_W'($urandom_range(127))
                                     : KEY_W'($urandom_range(8'h58, 1));
      press_release(key);
    end else if (pick < 68) begin
      key = ($urandom_range(1) == 0) ? KEY_LSHIFT : KEY_RSHIFT;
      send_code({1'b0, key});
      n = $urandom_range(3, 1);
      repeat (n) press_release(KEY_W'($urandom_range(127)));
      send_code({1'b1, key});
    end else if (pick < 78) begin
      case ($urandom_range(2))
        0: press_release(KEY_CAPS);
        1: press_release(KEY_NUM);
        default: press_release(KEY_SCROLL);
      endcase
    end else begin
      send_code(CODE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase_start;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    codes_ch.valid     = 1'b0;
    codes_ch.scan_code = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    sent               = 0;
    // Field extremes, letters with and without shift and caps, both shifts
    // overlapping, lock toggles and their releases, a release of a shift that
    // is not held, the acknowledge and resend bytes, and the shifted-only keys.
    directed_codes = '{8'h00, 8'hff, 8'h80, 8'h1e, 8'h9e, 8'h2a, 8'h1e, 8'h02,
                       8'h36, 8'haa, 8'h1e, 8'hb6, 8'h3a, 8'hba, 8'h1e, 8'h2a,
                       8'h1e, 8'h73, 8'h7d, 8'haa, 8'h45, 8'h46, 8'hc5, 8'hb6,
                       8'hfa, 8'hfe};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_boot_locks('0);
    for (int i = 0; i < DIRECTED_LEN; i++) send_code(directed_codes[i]);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      if (phase == 0) write_boot_locks(3'b111);
      else if (phase == 1) write_boot_locks(3'b000);
      else write_boot_locks(LOCK_W'($urandom_range(7)));
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) random_traffic();
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d scan codes and %0d result beats over %0d phases", sent,
             checked, PHASES);
    $display("Boot lock settings included all clear and all set, with idle and stall mixes");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ scancode_to_ascii_decoder_top.f @@
+incdir+src
src/scd_pkg.sv
src/scd_channels.sv
src/scd_in_stage.sv
src/scd_decode.sv
src/scd_out_stage.sv
src/scancode_to_ascii_decoder_top.sv
tb/scd_checker.sv
tb/tb.sv
